// ===== rtl/etb_pkg.sv =====
// Shared types and constants for the elimination tree builder.
`default_nettype none

package etb_pkg;

    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int PV_W  = 11;
    localparam int OP_W  = 2;

    localparam logic signed [PV_W-1:0] NO_PARENT        = -11'sd1;
    localparam logic [CNT_W-1:0]       NODE_COUNT_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_QREAD
    } t_state;

    typedef struct packed {
        logic signed [PV_W-1:0] parent_value;
        logic                   linked;
        logic                   ignored;
        logic                   error;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/etb_if.sv =====
// Handshake channels of the elimination tree builder: requests, results, configuration.
`default_nettype none

interface etb_req_if;
    logic                          valid;
    logic                          ready;
    logic [etb_pkg::OP_W-1:0]      op;
    logic [etb_pkg::IDX_W-1:0]     row_index;
    logic [etb_pkg::IDX_W-1:0]     col_index;

    modport source (output valid, output op, output row_index, output col_index, input ready);
    modport sink   (input valid, input op, input row_index, input col_index, output ready);
endinterface

interface etb_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [etb_pkg::PV_W-1:0]  parent_value;
    logic                             linked;
    logic                             ignored;
    logic                             error;

    modport source (output valid, output parent_value, output linked, output ignored,
                    output error, input ready);
    modport sink   (input valid, input parent_value, input linked, input ignored,
                    input error, output ready);
endinterface

interface etb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [etb_pkg::CNT_W-1:0]     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/elimination_tree_builder.sv =====
// Top level of the elimination tree builder: node count register, sequencer and link store.
// A linking entry climbs the parent links, one store read a cycle.
// One item at a time: the next is taken in the cycle after its predecessor's result is
// registered at the earliest, once that result is transferred or leaves in the same cycle.
// Synchronous active-low reset sets node_count to 1024 and starts a sweep writing -1 to
// every link; no item is accepted until it ends, configuration writes always are.
`default_nettype none

module elimination_tree_builder #(
    parameter int MAX_NODES = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    etb_cfg_if.sink    i_cfg,
    etb_req_if.sink    i_req,
    etb_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(MAX_NODES);

    logic [etb_pkg::CNT_W-1:0] r_node_count;
    logic                      we;
    logic [AW-1:0]             waddr;
    logic [etb_pkg::PV_W-1:0]  wdata;
    logic [AW-1:0]             raddr;
    logic [etb_pkg::PV_W-1:0]  rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= etb_pkg::NODE_COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_node_count <= i_cfg.data;
        end
    end

    etb_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (r_node_count),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    etb_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (etb_pkg::PV_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/etb_ram.sv =====
// Parent link store: one write port and one registered read port.
`default_nettype none

module etb_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/etb_ctrl.sv =====
// Sequencer for the elimination tree: clearing sweep, root climb, link update and queries.
`default_nettype none

module etb_ctrl #(
    parameter int MAX_NODES = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [etb_pkg::CNT_W-1:0]          i_node_count,
    etb_req_if.sink                                 i_req,
    etb_rsp_if.source                               o_rsp,
    output logic                                    o_we,
    output logic [$clog2(MAX_NODES)-1:0]            o_waddr,
    output logic [etb_pkg::PV_W-1:0]                o_wdata,
    output logic [$clog2(MAX_NODES)-1:0]            o_raddr,
    input  wire logic [etb_pkg::PV_W-1:0]           i_rdata
);

    localparam int AW = $clog2(MAX_NODES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

    etb_pkg::t_state r_state, n_state;
    logic [etb_pkg::IDX_W-1:0] r_node, n_node;
    logic [etb_pkg::IDX_W-1:0] r_col, n_col;
    logic [etb_pkg::IDX_W-1:0] r_last_col, n_last_col;
    logic [AW-1:0]             r_addr, n_addr;
    logic                      r_clr_rsp, n_clr_rsp;
    logic                      r_out_valid, n_out_valid;
    etb_pkg::t_rsp             r_out, n_out;

    logic                      req_ready;
    logic                      req_xfer;
    logic                      row_ok;
    logic                      col_ok;
    logic                      add_ok;
    logic                      above_diag;
    logic                      up_is_root;
    logic [etb_pkg::IDX_W-1:0] up_node;

    // Ready again as soon as the pending result is taken in the same cycle.
    assign req_ready = (r_state == etb_pkg::ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign req_xfer  = i_req.valid && req_ready;

    assign row_ok = ({1'b0, i_req.row_index} < i_node_count) &&
                    (32'(i_req.row_index) < MAX_NODES);
    assign col_ok = ({1'b0, i_req.col_index} < i_node_count) &&
                    (32'(i_req.col_index) < MAX_NODES);
    assign add_ok     = row_ok && col_ok && (i_req.col_index >= r_last_col);
    assign above_diag = i_req.row_index < i_req.col_index;

    assign up_node    = i_rdata[etb_pkg::IDX_W-1:0];
    assign up_is_root = i_rdata[etb_pkg::PV_W-1] || (32'(up_node) >= MAX_NODES);

    always_comb begin
        n_state = r_state;
        case (r_state)
            etb_pkg::ST_CLEAR: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = etb_pkg::ST_IDLE;
                end
            end
            etb_pkg::ST_IDLE: begin
                if (req_xfer) begin
                    case (etb_pkg::t_op'(i_req.op))
                        etb_pkg::OP_ADD: begin
                            if (add_ok && above_diag) begin
                                n_state = etb_pkg::ST_WALK;
                            end
                        end
                        etb_pkg::OP_QUERY: begin
                            if (row_ok) begin
                                n_state = etb_pkg::ST_QREAD;
                            end
                        end
                        etb_pkg::OP_CLEAR: begin
                            n_state = etb_pkg::ST_CLEAR;
                        end
                        default: begin
                            n_state = etb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            etb_pkg::ST_WALK: begin
                if (up_is_root) begin
                    n_state = etb_pkg::ST_IDLE;
                end
            end
            etb_pkg::ST_QREAD: begin
                n_state = etb_pkg::ST_IDLE;
            end
            default: begin
                n_state = etb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_node      = r_node;
        n_col       = r_col;
        n_last_col  = r_last_col;
        n_addr      = r_addr;
        n_clr_rsp   = r_clr_rsp;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_we        = 1'b0;
        o_waddr     = r_addr;
        o_wdata     = etb_pkg::NO_PARENT;
        o_raddr     = AW'(i_req.row_index);

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            etb_pkg::ST_CLEAR: begin
                o_we       = 1'b1;
                n_last_col = '0;
                n_addr     = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_addr    = '0;
                    n_clr_rsp = 1'b0;
                    if (r_clr_rsp) begin
                        n_out_valid        = 1'b1;
                        n_out.parent_value = etb_pkg::NO_PARENT;
                        n_out.linked       = 1'b0;
                        n_out.ignored      = 1'b0;
                        n_out.error        = 1'b0;
                    end
                end
            end
            etb_pkg::ST_IDLE: begin
                if (req_xfer) begin
                    n_out.parent_value = etb_pkg::NO_PARENT;
                    n_out.linked       = 1'b0;
                    n_out.ignored      = 1'b0;
                    n_out.error        = 1'b0;
                    case (etb_pkg::t_op'(i_req.op))
                        etb_pkg::OP_ADD: begin
                            if (!add_ok) begin
                                n_out_valid = 1'b1;
                                n_out.error = 1'b1;
                            end else begin
                                n_last_col = i_req.col_index;
                                if (!above_diag) begin
                                    n_out_valid   = 1'b1;
                                    n_out.ignored = 1'b1;
                                end else begin
                                    n_node = i_req.row_index;
                                    n_col  = i_req.col_index;
                                end
                            end
                        end
                        etb_pkg::OP_QUERY: begin
                            if (!row_ok) begin
                                n_out_valid = 1'b1;
                                n_out.error = 1'b1;
                            end
                        end
                        etb_pkg::OP_CLEAR: begin
                            n_addr    = '0;
                            n_clr_rsp = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out.error = 1'b1;
                        end
                    endcase
                end
            end
            etb_pkg::ST_WALK: begin
                // One parent link is followed per cycle until a node without a parent.
                o_raddr = AW'(up_node);
                if (up_is_root) begin
                    n_out_valid        = 1'b1;
                    n_out.parent_value = signed'({1'b0, r_node});
                    n_out.ignored      = 1'b0;
                    n_out.error        = 1'b0;
                    n_out.linked       = (r_node != r_col);
                    if (r_node != r_col) begin
                        o_we    = 1'b1;
                        o_waddr = AW'(r_node);
                        o_wdata = {1'b0, r_col};
                    end
                end else begin
                    n_node = up_node;
                end
            end
            etb_pkg::ST_QREAD: begin
                n_out_valid        = 1'b1;
                n_out.parent_value = signed'(i_rdata);
                n_out.linked       = 1'b0;
                n_out.ignored      = 1'b0;
                n_out.error        = 1'b0;
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= etb_pkg::ST_CLEAR;
            r_addr      <= '0;
            r_clr_rsp   <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_col  <= '0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_clr_rsp   <= n_clr_rsp;
            r_out_valid <= n_out_valid;
            r_last_col  <= n_last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_col  <= n_col;
        r_out  <= n_out;
    end

    assign i_req.ready        = req_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.parent_value = r_out.parent_value;
    assign o_rsp.linked       = r_out.linked;
    assign o_rsp.ignored      = r_out.ignored;
    assign o_rsp.error        = r_out.error;

    // Parents always lie above their children, so the climb never passes the column.
    a_walk_below_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == etb_pkg::ST_WALK) |-> (r_node <= r_col))
        else $error("climb passed the column");

    a_link_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && r_state == etb_pkg::ST_WALK) |->
        (o_wdata == {1'b0, r_col} && r_node != r_col))
        else $error("bad link write");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == etb_pkg::ST_CLEAR || r_state == etb_pkg::ST_WALK))
        else $error("store written outside sweep or link");

    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == etb_pkg::ST_CLEAR && !r_out_valid && !r_clr_rsp))
        else $error("reset did not start a silent sweep");

endmodule

`default_nettype wire

// ===== tb/etb_checker.sv =====
// Checker for the elimination tree builder: mirrors the parent links and compares every result.
module etb_checker #(
    parameter int MAX_NODES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    etb_cfg_if   i_cfg,
    etb_req_if   i_req,
    etb_rsp_if   i_rsp,
    output int   o_fail_count = 0,
    output int   o_pending = 0
);

    logic signed [etb_pkg::PV_W-1:0] parent_of [MAX_NODES];
    logic [etb_pkg::IDX_W-1:0]       last_col;
    logic [etb_pkg::CNT_W-1:0]       node_count;
    etb_pkg::t_rsp                   tree_rsp_due [$];

    function automatic void clear_tree();
        for (int i = 0; i < MAX_NODES; i++) begin
            parent_of[i] = etb_pkg::NO_PARENT;
        end
        last_col = '0;
    endfunction

    // Applies one request to the mirrored tree and returns the result it should give.
    function automatic etb_pkg::t_rsp predict_tree_step(logic [etb_pkg::OP_W-1:0] op,
                                                        logic [etb_pkg::IDX_W-1:0] row,
                                                        logic [etb_pkg::IDX_W-1:0] col);
        etb_pkg::t_rsp res;
        int unsigned   live;
        int unsigned   node;
        int unsigned   steps;
        res = '0;
        res.parent_value = etb_pkg::NO_PARENT;
        live = (node_count > MAX_NODES) ? MAX_NODES : node_count;
        case (op)
            etb_pkg::OP_ADD: begin
                if (col < last_col || row >= live || col >= live) begin
                    res.error = 1'b1;
                end else begin
                    last_col = col;
                    if (row >= col) begin
                        res.ignored = 1'b1;
                    end else begin
                        node  = row;
                        steps = 0;
                        while (steps < MAX_NODES && parent_of[node] >= 0) begin
                            node = int'(parent_of[node]);
                            steps++;
                        end
                        res.parent_value = etb_pkg::PV_W'(node);
                        if (node != col) begin
                            parent_of[node] = etb_pkg::PV_W'(col);
                            res.linked      = 1'b1;
                        end
                    end
                end
            end
            etb_pkg::OP_QUERY: begin
                if (row >= live) begin
                    res.error = 1'b1;
                end else begin
                    res.parent_value = parent_of[row];
                end
            end
            etb_pkg::OP_CLEAR: begin
                clear_tree();
            end
            default: begin
                res.error = 1'b1;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        etb_pkg::t_rsp due;
        bit            bad;
        if (!i_rst_n) begin
            clear_tree();
            node_count = etb_pkg::NODE_COUNT_RESET;
            tree_rsp_due.delete();
        end else begin
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1) begin
                node_count = i_cfg.data;
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                tree_rsp_due.push_back(predict_tree_step(i_req.op, i_req.row_index,
                                                         i_req.col_index));
            end
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (tree_rsp_due.size() == 0) begin
                    $display("%0t: result transfer with nothing outstanding: parent_value %0d",
                             $time, i_rsp.parent_value);
                    o_fail_count++;
                end else begin
                    due = tree_rsp_due.pop_front();
                    bad = 1'b0;
                    if (i_rsp.parent_value !== due.parent_value) begin
                        $display("%0t: parent_value expected %0d, got %0d",
                                 $time, due.parent_value, i_rsp.parent_value);
                        bad = 1'b1;
                    end
                    if (i_rsp.linked !== due.linked) begin
                        $display("%0t: linked expected %0b, got %0b",
                                 $time, due.linked, i_rsp.linked);
                        bad = 1'b1;
                    end
                    if (i_rsp.ignored !== due.ignored) begin
                        $display("%0t: ignored expected %0b, got %0b",
                                 $time, due.ignored, i_rsp.ignored);
                        bad = 1'b1;
                    end
                    if (i_rsp.error !== due.error) begin
                        $display("%0t: error expected %0b, got %0b",
                                 $time, due.error, i_rsp.error);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = tree_rsp_due.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the elimination tree builder: clock, reset, stimulus and verdict.
module tb;

    localparam int                       NODES       = 1024;
    localparam logic [etb_pkg::OP_W-1:0] OP_UNKNOWN  = 2'd3;
    localparam int                       ITEM_TARGET = 1600;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SELDOM,
        RX_EVERY_EIGHTH
    } t_rx_mode;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   burst_left = 0;
    int   items_sent = 0;

    t_rx_mode    rx_mode = RX_ALWAYS;
    int          rx_mode_left = 0;
    logic [2:0]  rx_tick = '0;

    etb_cfg_if cfg_ch ();
    etb_req_if req_ch ();
    etb_rsp_if rsp_ch ();

    elimination_tree_builder #(.MAX_NODES(NODES)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    etb_checker #(.MAX_NODES(NODES)) chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The result side switches between stall patterns.
    always @(negedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(32, 300);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            RX_ALWAYS:       rsp_ch.ready = 1'b1;
            RX_MOSTLY:       rsp_ch.ready = ($urandom_range(0, 3) != 0);
            RX_SELDOM:       rsp_ch.ready = ($urandom_range(0, 3) == 0);
            RX_EVERY_EIGHTH: rsp_ch.ready = (rx_tick == 3'd0);
            default:         rsp_ch.ready = 1'b1;
        endcase
    end

    task automatic send(logic [etb_pkg::OP_W-1:0] op, logic [etb_pkg::IDX_W-1:0] row,
                        logic [etb_pkg::IDX_W-1:0] col);
        @(negedge clk);
        if (burst_left == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            // Now and then a long burst with no gaps at all.
            burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 20);
        end
        burst_left--;
        req_ch.valid     = 1'b1;
        req_ch.op        = op;
        req_ch.row_index = row;
        req_ch.col_index = col;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        items_sent++;
    endtask

    // Holds off new requests until every outstanding result has been received.
    task automatic settle_block();
        @(negedge clk);
        req_ch.valid = 1'b0;
        burst_left   = 0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_node_count(int unsigned value);
        settle_block();
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = etb_pkg::CNT_W'(value);
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // One phase: a fresh tree built from column-ordered entries, mixed with queries and
    // malformed requests. The column tracker follows the block's last accepted column.
    task automatic run_phase(int unsigned cfg_value, int unsigned len, bit hold_midway);
        int unsigned live;
        int unsigned col;
        int unsigned row;
        int unsigned step;
        int unsigned pick;
        int unsigned lim;
        int unsigned c;
        live = (cfg_value > NODES) ? NODES : cfg_value;
        write_node_count(cfg_value);
        send(etb_pkg::OP_CLEAR, etb_pkg::IDX_W'($urandom), etb_pkg::IDX_W'($urandom));
        col  = 0;
        step = live / 24 + 1;
        for (int i = 0; i < len; i++) begin
            if (hold_midway && i == len / 2) begin
                settle_block();
            end
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                col = col + $urandom_range(0, step);
                if (col > live - 1) begin
                    col = live - 1;
                end
                if (col == 0) begin
                    row = 0;
                end else if ($urandom_range(0, 1) == 1) begin
                    lim = (col - 1 < 3) ? col - 1 : 3;
                    row = col - 1 - $urandom_range(0, lim);
                end else begin
                    row = $urandom_range(0, col - 1);
                end
                send(etb_pkg::OP_ADD, etb_pkg::IDX_W'(row), etb_pkg::IDX_W'(col));
            end else if (pick < 84) begin
                row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NODES - 1)
                                                  : $urandom_range(0, live - 1);
                send(etb_pkg::OP_QUERY, etb_pkg::IDX_W'(row), etb_pkg::IDX_W'($urandom));
            end else if (pick < 88) begin
                send(etb_pkg::OP_ADD, etb_pkg::IDX_W'($urandom_range(col, live - 1)),
                     etb_pkg::IDX_W'(col));
            end else if (pick < 92 && col > 0) begin
                send(etb_pkg::OP_ADD, etb_pkg::IDX_W'($urandom_range(0, live - 1)),
                     etb_pkg::IDX_W'($urandom_range(0, col - 1)));
            end else if (pick < 96) begin
                if (live < NODES) begin
                    if ($urandom_range(0, 1) == 1) begin
                        send(etb_pkg::OP_ADD, etb_pkg::IDX_W'($urandom_range(live, NODES - 1)),
                             etb_pkg::IDX_W'(col));
                    end else begin
                        send(etb_pkg::OP_ADD, etb_pkg::IDX_W'($urandom_range(0, live - 1)),
                             etb_pkg::IDX_W'($urandom_range(live, NODES - 1)));
                    end
                end else begin
                    // Every index is in range here, so a random entry may be accepted.
                    row = $urandom_range(0, NODES - 1);
                    c   = $urandom_range(0, NODES - 1);
                    if (c >= col) begin
                        col = c;
                    end
                    send(etb_pkg::OP_ADD, etb_pkg::IDX_W'(row), etb_pkg::IDX_W'(c));
                end
            end else if (pick < 98) begin
                send(OP_UNKNOWN, etb_pkg::IDX_W'($urandom), etb_pkg::IDX_W'($urandom));
            end else begin
                send(etb_pkg::OP_CLEAR, etb_pkg::IDX_W'($urandom), etb_pkg::IDX_W'($urandom));
                col = 0;
            end
        end
        if (live <= 64) begin
            for (int q = 0; q < live; q++) begin
                send(etb_pkg::OP_QUERY, etb_pkg::IDX_W'(q), etb_pkg::IDX_W'($urandom));
            end
        end
    endtask

    initial begin
        int unsigned cfg_value;
        int unsigned len;
        int          phase;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.op        = etb_pkg::OP_ADD;
        req_ch.row_index = '0;
        req_ch.col_index = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed checks at the reset node count.
        send(etb_pkg::OP_QUERY, 10'd0, 10'd0);
        send(etb_pkg::OP_QUERY, 10'd1023, 10'd0);
        send(etb_pkg::OP_ADD, 10'd0, 10'd1);
        send(etb_pkg::OP_ADD, 10'd0, 10'd1);
        send(etb_pkg::OP_ADD, 10'd1, 10'd1);
        send(etb_pkg::OP_ADD, 10'd5, 10'd3);
        send(etb_pkg::OP_ADD, 10'd0, 10'd2);
        send(etb_pkg::OP_ADD, 10'd2, 10'd1023);
        send(etb_pkg::OP_ADD, 10'd0, 10'd1023);
        send(etb_pkg::OP_ADD, 10'd0, 10'd1023);
        send(etb_pkg::OP_ADD, 10'd1023, 10'd1023);
        send(etb_pkg::OP_QUERY, 10'd0, 10'd0);
        send(etb_pkg::OP_QUERY, 10'd1, 10'd0);
        send(OP_UNKNOWN, 10'd1023, 10'd1023);
        send(etb_pkg::OP_CLEAR, 10'd1023, 10'd1023);
        send(etb_pkg::OP_QUERY, 10'd1, 10'd0);
        send(etb_pkg::OP_ADD, 10'd3, 10'd4);
        // With no nodes in use every request is out of range.
        write_node_count(0);
        send(etb_pkg::OP_ADD, 10'd0, 10'd0);
        send(etb_pkg::OP_QUERY, 10'd0, 10'd0);
        write_node_count(1);
        send(etb_pkg::OP_ADD, 10'd0, 10'd0);
        send(etb_pkg::OP_ADD, 10'd0, 10'd1);
        send(etb_pkg::OP_QUERY, 10'd0, 10'd0);
        send(etb_pkg::OP_QUERY, 10'd1, 10'd0);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: cfg_value = 2;
                1: cfg_value = NODES;
                2: cfg_value = (1 << etb_pkg::CNT_W) - 1;
                3: cfg_value = 1;
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: cfg_value = $urandom_range(2, 64);
                        6, 7, 8:          cfg_value = $urandom_range(65, 400);
                        default:          cfg_value = $urandom_range(401, NODES);
                    endcase
                end
            endcase
            len = (cfg_value <= 64) ? $urandom_range(30, 90) : $urandom_range(40, 120);
            run_phase(cfg_value, len, phase % 4 == 1);
            phase++;
        end

        settle_block();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[elimination_tree_builder] OK");
        end else begin
            $display("[elimination_tree_builder] ERROR");
        end
        $finish;
    end

    // Far beyond the slowest correct run, even with every entry climbing the full tree.
    initial begin
        #40000000;
        $display("[elimination_tree_builder] ERROR");
        $finish;
    end

endmodule
